/* src/itoa_pkg.sv */
// Package for the integer to padded ASCII formatter.
// Holds sizing constants, radix codes, ASCII codes and the digit-to-character map.
// No dependencies.
package itoa_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int VALUE_BITS = 32;
  localparam int PORT_BITS  = 32;

  localparam int BIN_DIGITS = VALUE_BITS;
  localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int DEC_DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;

  localparam int WORK_W  = DEC_DIGITS * 4;
  localparam int ND_W    = $clog2(VALUE_BITS + 1);
  localparam int BIT_W   = $clog2(VALUE_BITS);
  localparam int CNT_W   = ($clog2(MAX_WIDTH + 1) > 7) ? $clog2(MAX_WIDTH + 1) : 7;

  localparam logic [1:0] BASE_BIN = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_DEC = 2'd2;
  localparam logic [1:0] BASE_HEX = 2'd3;

  localparam logic [6:0] CH_ZERO    = 7'h30;
  localparam logic [6:0] CH_UPPER_A = 7'h41;
  localparam logic [6:0] CH_LOWER_A = 7'h61;
  localparam logic [6:0] CH_MINUS   = 7'h2d;
  localparam logic [6:0] CH_SPACE   = 7'h20;
  localparam logic [3:0] DIGIT_TEN  = 4'd10;

  function automatic logic [6:0] digit_char(input logic [3:0] d, input logic up);
    logic [6:0] base_c;
    base_c = up ? CH_UPPER_A : CH_LOWER_A;
    if (d < DIGIT_TEN) begin
      digit_char = CH_ZERO + {3'b000, d};
    end else begin
      digit_char = base_c + {3'b000, d - DIGIT_TEN};
    end
  endfunction

endpackage

/* src/integer_to_padded_ascii.sv */
// Integer to padded ASCII formatter, top level.
// Converts one magnitude per input transfer into a stream of ASCII characters.
// Depends on itoa_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries the magnitude, radix select,
//   sign flag, field width and the left-adjust, zero-pad and upper-case flags.
//   Output channel (out_valid_o/out_ready_i) carries one character per transfer,
//   leftmost first, with last_o set on the final character of the number.
//   in_ready_o is high only while the block is idle; one number is in flight.
// Sequencing:
//   Decimal runs a shift-and-add-3 loop over the VALUE_BITS (32) input bits; other
//   radices skip it. A leading-zero strip then drops leading zero digits while at
//   least one digit remains. After that one character leaves per cycle while
//   out_ready_i is high; the next number is not taken until the last one is sent.
//   An item is 1 to MAX_WIDTH = 64 characters long.
// Reset:
//   rst_ni clears the sequencer to idle; no output is pending after reset.
// Stalls:
//   A low out_ready_i holds the current character and the sequencer; nothing is
//   dropped and the next number waits until the last character is transferred.
module integer_to_padded_ascii
  import itoa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PORT_BITS-1:0] value_i,
  input  logic [1:0]           base_select_i,
  input  logic                 negative_i,
  input  logic [6:0]           field_width_i,
  input  logic                 left_adjust_i,
  input  logic                 zero_pad_i,
  input  logic                 upper_case_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [6:0]           character_o,
  output logic                 last_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DABBLE = 6'b000010,
    ST_NORM   = 6'b000100,
    ST_PAD    = 6'b001000,
    ST_SIGN   = 6'b010000,
    ST_DIGIT  = 6'b100000
  } state_e;

  state_e                  state_q, state_d;
  logic [WORK_W-1:0]       work_q, work_d;
  logic [VALUE_BITS-1:0]   shreg_q, shreg_d;
  logic [BIT_W-1:0]        bit_cnt_q, bit_cnt_d;
  logic [ND_W-1:0]         nd_q, nd_d;
  logic [CNT_W-1:0]        pad_q, pad_d;
  logic [CNT_W-1:0]        fw_q, fw_d;
  logic [1:0]              base_q, base_d;
  logic                    neg_q, neg_d;
  logic                    ladj_q, ladj_d;
  logic                    zmode_q, zmode_d;
  logic                    upper_q, upper_d;

  logic [VALUE_BITS-1:0]   val;
  logic [CNT_W-1:0]        fw_ext;
  logic [CNT_W-1:0]        body;
  logic [CNT_W-1:0]        pad_calc;
  logic [3:0]              top4;
  logic [3:0]              top_digit;
  logic [WORK_W-1:0]       work_shift;
  logic [WORK_W-1:0]       work_adj;
  logic                    in_xfer;
  logic                    out_xfer;
  logic                    norm_done;

  assign val      = value_i[VALUE_BITS-1:0];
  assign fw_ext   = CNT_W'(field_width_i);
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  assign top4 = work_q[WORK_W-1 -: 4];

  always_comb begin
    case (base_q)
      BASE_BIN: begin
        top_digit  = {3'b000, top4[3]};
        work_shift = work_q << 1;
      end
      BASE_OCT: begin
        top_digit  = {1'b0, top4[3:1]};
        work_shift = work_q << 3;
      end
      default: begin
        top_digit  = top4;
        work_shift = work_q << 4;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < DEC_DIGITS; k++) begin
      work_adj[k*4 +: 4] = (work_q[k*4 +: 4] > 4'd4) ? work_q[k*4 +: 4] + 4'd3
                                                      : work_q[k*4 +: 4];
    end
  end

  assign norm_done = (nd_q == ND_W'(1)) || (top_digit != 4'd0);
  assign body      = CNT_W'(nd_q) + CNT_W'(neg_q);
  assign pad_calc  = (fw_q > body) ? fw_q - body : '0;

  always_comb begin
    state_d   = state_q;
    work_d    = work_q;
    shreg_d   = shreg_q;
    bit_cnt_d = bit_cnt_q;
    nd_d      = nd_q;
    pad_d     = pad_q;
    fw_d      = fw_q;
    base_d    = base_q;
    neg_d     = neg_q;
    ladj_d    = ladj_q;
    zmode_d   = zmode_q;
    upper_d   = upper_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          base_d    = base_select_i;
          neg_d     = negative_i;
          ladj_d    = left_adjust_i;
          zmode_d   = zero_pad_i && !left_adjust_i;
          upper_d   = upper_case_i;
          fw_d      = (fw_ext > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : fw_ext;
          shreg_d   = val;
          bit_cnt_d = BIT_W'(VALUE_BITS - 1);
          case (base_select_i)
            BASE_BIN: begin
              work_d  = WORK_W'(val) << (WORK_W - BIN_DIGITS);
              nd_d    = ND_W'(BIN_DIGITS);
              state_d = ST_NORM;
            end
            BASE_OCT: begin
              work_d  = WORK_W'(val) << (WORK_W - OCT_DIGITS * 3);
              nd_d    = ND_W'(OCT_DIGITS);
              state_d = ST_NORM;
            end
            BASE_HEX: begin
              work_d  = WORK_W'(val) << (WORK_W - HEX_DIGITS * 4);
              nd_d    = ND_W'(HEX_DIGITS);
              state_d = ST_NORM;
            end
            default: begin
              work_d  = '0;
              nd_d    = ND_W'(DEC_DIGITS);
              state_d = ST_DABBLE;
            end
          endcase
        end
      end
      ST_DABBLE: begin
        work_d  = {work_adj[WORK_W-2:0], shreg_q[VALUE_BITS-1]};
        shreg_d = shreg_q << 1;
        if (bit_cnt_q == '0) begin
          state_d = ST_NORM;
        end else begin
          bit_cnt_d = bit_cnt_q - BIT_W'(1);
        end
      end
      ST_NORM: begin
        if (norm_done) begin
          pad_d = pad_calc;
          if (ladj_q) begin
            state_d = neg_q ? ST_SIGN : ST_DIGIT;
          end else if (zmode_q) begin
            state_d = neg_q ? ST_SIGN : ((pad_calc != '0) ? ST_PAD : ST_DIGIT);
          end else begin
            state_d = (pad_calc != '0) ? ST_PAD : (neg_q ? ST_SIGN : ST_DIGIT);
          end
        end else begin
          work_d = work_shift;
          nd_d   = nd_q - ND_W'(1);
        end
      end
      ST_PAD: begin
        if (out_xfer) begin
          pad_d = pad_q - CNT_W'(1);
          if (pad_q == CNT_W'(1)) begin
            if (ladj_q) begin
              state_d = ST_IDLE;
            end else if (zmode_q) begin
              state_d = ST_DIGIT;
            end else begin
              state_d = neg_q ? ST_SIGN : ST_DIGIT;
            end
          end
        end
      end
      ST_SIGN: begin
        if (out_xfer) begin
          state_d = (zmode_q && (pad_q != '0)) ? ST_PAD : ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_xfer) begin
          work_d = work_shift;
          nd_d   = nd_q - ND_W'(1);
          if (nd_q == ND_W'(1)) begin
            state_d = (ladj_q && (pad_q != '0)) ? ST_PAD : ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q    <= work_d;
    shreg_q   <= shreg_d;
    bit_cnt_q <= bit_cnt_d;
    nd_q      <= nd_d;
    pad_q     <= pad_d;
    fw_q      <= fw_d;
    base_q    <= base_d;
    neg_q     <= neg_d;
    ladj_q    <= ladj_d;
    zmode_q   <= zmode_d;
    upper_q   <= upper_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_PAD) || (state_q == ST_SIGN) || (state_q == ST_DIGIT);

  always_comb begin
    case (state_q)
      ST_PAD: begin
        character_o = zmode_q ? CH_ZERO : CH_SPACE;
        last_o      = ladj_q && (pad_q == CNT_W'(1));
      end
      ST_SIGN: begin
        character_o = CH_MINUS;
        last_o      = 1'b0;
      end
      ST_DIGIT: begin
        character_o = digit_char(top_digit, upper_q);
        last_o      = (nd_q == ND_W'(1)) && !(ladj_q && (pad_q != '0));
      end
      default: begin
        character_o = CH_SPACE;
        last_o      = 1'b0;
      end
    endcase
  end

  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a character is pending");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> in_ready_o)
    else $error("block not idle after last character");

  a_digit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT) |-> (nd_q != '0))
    else $error("digit phase with no digits left");

  a_pad_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAD) |-> (pad_q != '0))
    else $error("pad phase with no padding left");

endmodule

/* dv/integer_to_padded_ascii_tb.sv */
// Testbench for integer_to_padded_ascii: drives directed and random numbers, flags and widths
// and checks every character against a local printf-style formatter.
// Depends on itoa_pkg and the integer_to_padded_ascii RTL.
module integer_to_padded_ascii_tb;
  import itoa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STUCK_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_NUMBERS = 140;

  typedef struct {
    logic [PORT_BITS-1:0] value;
    logic [1:0]           base_sel;
    logic                 negative;
    logic [6:0]           width;
    logic                 left_adjust;
    logic                 zero_pad;
    logic                 upper_case;
  } number_t;

  typedef struct {
    logic [6:0] character;
    logic       last;
  } glyph_t;

  class text_board;
    glyph_t expected_glyphs[$];
    int     mismatches = 0;

    function int pending();
      return expected_glyphs.size();
    endfunction

    function void report_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    function void note_number(number_t n);
      logic [VALUE_BITS-1:0] rest;
      logic [VALUE_BITS-1:0] radix;
      logic [3:0]            d;
      logic [6:0]            digits[$];
      logic [6:0]            text[$];
      glyph_t                g;
      int                    fw, body, total;
      rest = n.value[VALUE_BITS-1:0];
      case (n.base_sel)
        BASE_BIN: radix = 2;
        BASE_OCT: radix = 8;
        BASE_DEC: radix = 10;
        default:  radix = 16;
      endcase
      fw = (n.width > MAX_WIDTH) ? MAX_WIDTH : int'(n.width);
      do begin
        d = 4'(rest % radix);
        if (d < DIGIT_TEN) begin
          digits.push_front(CH_ZERO + 7'(d));
        end else begin
          digits.push_front((n.upper_case ? CH_UPPER_A : CH_LOWER_A) + 7'(d - DIGIT_TEN));
        end
        rest = rest / radix;
      end while (rest != 0 && digits.size() < 64);
      body = digits.size() + (n.negative ? 1 : 0);
      total = (fw > body) ? fw : body;
      if (n.left_adjust) begin
        if (n.negative) text.push_back(CH_MINUS);
        foreach (digits[i]) text.push_back(digits[i]);
        while (text.size() < total) text.push_back(CH_SPACE);
      end else if (n.zero_pad) begin
        if (n.negative) text.push_back(CH_MINUS);
        repeat (total - body) text.push_back(CH_ZERO);
        foreach (digits[i]) text.push_back(digits[i]);
      end else begin
        repeat (total - body) text.push_back(CH_SPACE);
        if (n.negative) text.push_back(CH_MINUS);
        foreach (digits[i]) text.push_back(digits[i]);
      end
      foreach (text[i]) begin
        g.character = text[i];
        g.last = (i == text.size() - 1);
        expected_glyphs.push_back(g);
      end
    endfunction

    function void check_glyph(logic [6:0] ch, logic last);
      glyph_t want;
      if (expected_glyphs.size() == 0) begin
        report_mismatch($sformatf("unexpected character %h '%c' last %b", ch, ch, last));
        return;
      end
      want = expected_glyphs.pop_front();
      if (ch !== want.character) begin
        report_mismatch($sformatf("character expected %h '%c' got %h '%c'",
                                  want.character, want.character, ch, ch));
      end
      if (last !== want.last) begin
        report_mismatch($sformatf("last on %h expected %b got %b",
                                  want.character, want.last, last));
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [PORT_BITS-1:0] value_i = '0;
  logic [1:0]           base_select_i = BASE_BIN;
  logic                 negative_i = 1'b0;
  logic [6:0]           field_width_i = '0;
  logic                 left_adjust_i = 1'b0;
  logic                 zero_pad_i = 1'b0;
  logic                 upper_case_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [6:0]           character_o;
  logic                 last_o;

  text_board board = new();
  int idle_pct = 25;
  int stall_left = 0;
  int stuck_cycles = 0;

  integer_to_padded_ascii u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .value_i       (value_i),
    .base_select_i (base_select_i),
    .negative_i    (negative_i),
    .field_width_i (field_width_i),
    .left_adjust_i (left_adjust_i),
    .zero_pad_i    (zero_pad_i),
    .upper_case_i  (upper_case_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .character_o   (character_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 4);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) board.check_glyph(character_o, last_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_number(input number_t n);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    value_i       <= n.value;
    base_select_i <= n.base_sel;
    negative_i    <= n.negative;
    field_width_i <= n.width;
    left_adjust_i <= n.left_adjust;
    zero_pad_i    <= n.zero_pad;
    upper_case_i  <= n.upper_case;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_number(n);
  endtask

  initial begin
    number_t n;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // value, base, negative, width, left adjust, zero pad, upper case
    send_number('{32'h0000_0000, BASE_DEC, 1'b0, 7'd0,   1'b0, 1'b0, 1'b0});
    send_number('{32'h0000_0000, BASE_DEC, 1'b1, 7'd0,   1'b0, 1'b0, 1'b0});
    send_number('{32'hffff_ffff, BASE_BIN, 1'b0, 7'd0,   1'b0, 1'b0, 1'b0});
    send_number('{32'hffff_ffff, BASE_BIN, 1'b1, 7'd64,  1'b0, 1'b1, 1'b0});
    send_number('{32'hffff_ffff, BASE_OCT, 1'b0, 7'd0,   1'b0, 1'b0, 1'b1});
    send_number('{32'hffff_ffff, BASE_DEC, 1'b1, 7'd12,  1'b0, 1'b0, 1'b0});
    send_number('{32'hdead_beef, BASE_HEX, 1'b0, 7'd0,   1'b0, 1'b0, 1'b1});
    send_number('{32'hdead_beef, BASE_HEX, 1'b1, 7'd0,   1'b0, 1'b0, 1'b0});
    send_number('{32'h0abc_def0, BASE_DEC, 1'b0, 7'd0,   1'b0, 1'b0, 1'b1});
    send_number('{32'h0000_002a, BASE_DEC, 1'b0, 7'd127, 1'b0, 1'b0, 1'b0});
    send_number('{32'h0000_002a, BASE_HEX, 1'b1, 7'd65,  1'b0, 1'b1, 1'b1});
    send_number('{32'h0000_002a, BASE_DEC, 1'b1, 7'd100, 1'b1, 1'b1, 1'b0});
    send_number('{32'h0000_3039, BASE_DEC, 1'b0, 7'd10,  1'b1, 1'b0, 1'b0});
    send_number('{32'h0001_e240, BASE_DEC, 1'b1, 7'd3,   1'b0, 1'b1, 1'b0});
    send_number('{32'h00c0_ffee, BASE_HEX, 1'b0, 7'd64,  1'b1, 1'b0, 1'b1});
    send_number('{32'h8000_0000, BASE_BIN, 1'b1, 7'd0,   1'b0, 1'b1, 1'b0});
    send_number('{32'h0000_0001, BASE_OCT, 1'b0, 7'd1,   1'b0, 1'b1, 1'b0});
    send_number('{32'h0000_3039, BASE_DEC, 1'b1, 7'd8,   1'b0, 1'b1, 1'b0});
    send_number('{32'h5555_5555, BASE_HEX, 1'b0, 7'd64,  1'b0, 1'b0, 1'b0});
    send_number('{32'haaaa_aaaa, BASE_BIN, 1'b1, 7'd33,  1'b0, 1'b0, 1'b1});
    send_number('{32'h0000_0000, BASE_HEX, 1'b1, 7'd5,   1'b0, 1'b1, 1'b1});
    send_number('{32'h0000_0007, BASE_OCT, 1'b0, 7'd4,   1'b1, 1'b1, 1'b1});

    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      if (i >= RANDOM_NUMBERS - 20) idle_pct = 0;
      else idle_pct = ((i / 20) % 3 == 2) ? 0 : 30;
      case ($urandom_range(0, 2))
        0:       n.value = $urandom;
        1:       n.value = $urandom_range(0, 20);
        default: n.value = $urandom >> $urandom_range(0, 31);
      endcase
      n.base_sel = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        6, 7:    n.width = 7'($urandom_range(17, 40));
        8:       n.width = 7'($urandom_range(41, 64));
        9:       n.width = 7'($urandom_range(65, 127));
        default: n.width = 7'($urandom_range(0, 16));
      endcase
      n.negative    = 1'($urandom);
      n.left_adjust = 1'($urandom);
      n.zero_pad    = 1'($urandom);
      n.upper_case  = 1'($urandom);
      send_number(n);
    end
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
